>>> rtl/crd_pkg.sv
// ----------------------------------------------------------------------------
// crd_pkg: shared types and constants of the cubic resampler
// Holds action codes, register indexes, widths and the controller command
// struct used between the controller and the datapath.
// ----------------------------------------------------------------------------
package crd_pkg;

  localparam int TrackFramesDefault  = 65536;
  localparam int FractionBitsDefault = 16;

  localparam int PosW   = 33;
  localparam int PitchW = 21;
  localparam int LenW   = 17;
  localparam int SampW  = 16;
  localparam int AddrInW = 16;
  localparam int CfgW   = 21;
  localparam int CfgIdxW = 1;

  localparam logic [15:0] LfsrReset  = 16'hbabe;
  localparam logic [20:0] PitchReset = 21'd65536;

  // Input action codes.
  localparam logic [1:0] ActWrite  = 2'd0;
  localparam logic [1:0] ActSetPos = 2'd1;
  localparam logic [1:0] ActTick   = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegPitch  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegLength = 1'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       write_frame;  // store the input frame
    logic       set_pos;      // load the play position
    logic       start_tick;   // latch the window base and fraction
    logic       read_en;      // issue a frame read for window tap read_tap
    logic [1:0] read_tap;
    logic       cap_en;       // capture the read data of tap cap_tap
    logic [1:0] cap_tap;
    logic       coef;         // form the cubic coefficients
    logic [1:0] horner;       // Horner step 1..3 (0 means none)
    logic       finish;       // dither, saturate and advance the position
  } crd_cmd_t;

endpackage

>>> rtl/crd_ram.sv
// ----------------------------------------------------------------------------
// crd_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module crd_ram #(
  parameter int Width = 32,
  parameter int Depth = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write or registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/crd_ctrl.sv
// ----------------------------------------------------------------------------
// crd_ctrl: sequencer of the cubic resampler
// Accepts input beats, steps the datapath through the four frame reads, the
// coefficient step and three Horner steps, and holds the output beat.
// ----------------------------------------------------------------------------
module crd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        action,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output crd_pkg::crd_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_R0, S_R1, S_R2, S_R3, S_CAP, S_COEF, S_H1, S_H2, S_H3, S_FIN
  } state_t;

  state_t state;
  logic   accept;
  logic   out_free;

  // An item is taken whenever the sequencer is idle; a waiting result only
  // holds back the final step of the next tick.
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Commands decoded from the state.
  always_comb begin
    cmd = '0;
    cmd.write_frame = accept && (action == crd_pkg::ActWrite);
    cmd.set_pos     = accept && (action == crd_pkg::ActSetPos);
    cmd.start_tick  = accept && (action == crd_pkg::ActTick);
    case (state)
      S_R0: begin
        cmd.read_en = 1'b1; cmd.read_tap = 2'd0;
      end
      S_R1: begin
        cmd.read_en = 1'b1; cmd.read_tap = 2'd1;
        cmd.cap_en = 1'b1; cmd.cap_tap = 2'd0;
      end
      S_R2: begin
        cmd.read_en = 1'b1; cmd.read_tap = 2'd2;
        cmd.cap_en = 1'b1; cmd.cap_tap = 2'd1;
      end
      S_R3: begin
        cmd.read_en = 1'b1; cmd.read_tap = 2'd3;
        cmd.cap_en = 1'b1; cmd.cap_tap = 2'd2;
      end
      S_CAP: begin
        cmd.cap_en = 1'b1; cmd.cap_tap = 2'd3;
      end
      S_COEF: cmd.coef = 1'b1;
      S_H1:   cmd.horner = 2'd1;
      S_H2:   cmd.horner = 2'd2;
      S_H3:   cmd.horner = 2'd3;
      S_FIN:  cmd.finish = out_free;
      default: ;
    endcase
  end

  // State register and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: if (accept && action == crd_pkg::ActTick) state <= S_R0;
        S_R0:   state <= S_R1;
        S_R1:   state <= S_R2;
        S_R2:   state <= S_R3;
        S_R3:   state <= S_CAP;
        S_CAP:  state <= S_COEF;
        S_COEF: state <= S_H1;
        S_H1:   state <= S_H2;
        S_H2:   state <= S_H3;
        S_H3:   state <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            state     <= S_IDLE;
            out_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/crd_datapath.sv
// ----------------------------------------------------------------------------
// crd_datapath: frame memory, position, cubic evaluation and dither
// Both channels run side by side; each Horner step uses one multiplier per
// channel, with the product added into a registered accumulator.
// ----------------------------------------------------------------------------
module crd_datapath #(
  parameter int TrackFrames  = crd_pkg::TrackFramesDefault,
  parameter int FractionBits = crd_pkg::FractionBitsDefault
) (
  input  logic                               clk,
  input  logic                               rst,
  input  crd_pkg::crd_cmd_t                  cmd,
  input  logic                               cfg_we,
  input  logic [crd_pkg::CfgIdxW-1:0]        cfg_idx,
  input  logic [crd_pkg::CfgW-1:0]           cfg_data,
  input  logic [crd_pkg::AddrInW-1:0]        frame_address,
  input  logic signed [crd_pkg::SampW-1:0]   left_sample,
  input  logic signed [crd_pkg::SampW-1:0]   right_sample,
  input  logic signed [crd_pkg::PosW-1:0]    start_position,
  output logic signed [crd_pkg::SampW-1:0]   left_out,
  output logic signed [crd_pkg::SampW-1:0]   right_out
);

  localparam int AW    = $clog2(TrackFrames);
  localparam int BaseW = crd_pkg::PosW - FractionBits;
  localparam int MuW   = 16;
  // Wide enough for an unclamped Horner value (about 2^35).
  localparam int HW    = 40;
  localparam int PW    = HW + MuW + 1;

  logic signed [crd_pkg::PitchW-1:0] pitch_step;
  logic [crd_pkg::LenW-1:0]          track_length;
  logic [crd_pkg::PosW-1:0]          play_position;
  logic [15:0]                       lfsr;
  logic signed [BaseW-1:0]           base;
  logic [MuW-1:0]                    mu;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_step   <= crd_pkg::PitchReset;
      track_length <= '0;
    end else if (cfg_we) begin
      if (cfg_idx == crd_pkg::RegPitch) begin
        pitch_step <= cfg_data[crd_pkg::PitchW-1:0];
      end else begin
        track_length <= cfg_data[crd_pkg::LenW-1:0];
      end
    end
  end

  // Frame memory: one access per cycle.
  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [31:0]      ram_rdata;
  logic signed [BaseW+2:0] tap_idx;
  logic             wr_ok;

  assign wr_ok  = ({{(32-crd_pkg::AddrInW){1'b0}}, frame_address} < 32'(TrackFrames));
  assign ram_we = cmd.write_frame && wr_ok;
  assign tap_idx = (BaseW+3)'(base) - (BaseW+3)'(1) + (BaseW+3)'(cmd.read_tap);
  always_comb begin
    if (cmd.write_frame) begin
      ram_addr = AW'(frame_address);
    end else begin
      ram_addr = AW'(tap_idx);
    end
  end

  crd_ram #(.Width(32), .Depth(TrackFrames)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({right_sample, left_sample}),
    .rdata (ram_rdata)
  );

  // Range check of each window tap, delayed to the read data.
  logic tap_ok, tap_ok_q;
  always_comb begin
    tap_ok = !tap_idx[BaseW+2]
             && ($signed(64'(tap_idx)) < $signed({47'd0, track_length}))
             && ($signed(64'(tap_idx)) < 64'(TrackFrames));
  end
  always_ff @(posedge clk) begin
    tap_ok_q <= tap_ok;
  end

  // Window samples per channel.
  logic signed [15:0] yl [4];
  logic signed [15:0] yr [4];
  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      yl[cmd.cap_tap] <= tap_ok_q ? ram_rdata[15:0]  : 16'sd0;
      yr[cmd.cap_tap] <= tap_ok_q ? ram_rdata[31:16] : 16'sd0;
    end
  end

  // Position, base and fraction.
  logic [crd_pkg::PosW-1:0] step_ext;
  always_comb begin
    if (FractionBits >= 16) begin
      step_ext = crd_pkg::PosW'($signed(pitch_step)) << (FractionBits - 16);
    end else begin
      step_ext = crd_pkg::PosW'($signed(pitch_step) >>> (16 - FractionBits));
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      play_position <= '0;
    end else if (cmd.set_pos) begin
      play_position <= start_position;
    end else if (cmd.finish) begin
      play_position <= play_position + step_ext;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.start_tick) begin
      base <= $signed(play_position[crd_pkg::PosW-1:FractionBits]);
      if (FractionBits >= 16) begin
        mu <= MuW'(play_position[FractionBits-1:0] >> (FractionBits - 16));
      end else begin
        mu <= MuW'({play_position[FractionBits-1:0], 16'd0} >> FractionBits);
      end
    end
  end

  // Coefficients a1..a3 and the Horner accumulators.
  logic signed [19:0] a1l, a2l, a3l, a1r, a2r, a3r;
  logic signed [HW-1:0] hl, hr;
  logic signed [19:0] a0l, a0r;
  logic signed [19:0] addl, addr_r;
  logic signed [PW-1:0] pl, pr;

  assign a0l = 20'(yl[3]) - 20'(yl[2]) - 20'(yl[0]) + 20'(yl[1]);
  assign a0r = 20'(yr[3]) - 20'(yr[2]) - 20'(yr[0]) + 20'(yr[1]);
  assign pl  = PW'(hl) * $signed({1'b0, mu});
  assign pr  = PW'(hr) * $signed({1'b0, mu});

  always_comb begin
    case (cmd.horner)
      2'd1:    begin addl = a1l; addr_r = a1r; end
      2'd2:    begin addl = a2l; addr_r = a2r; end
      default: begin addl = a3l; addr_r = a3r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.coef) begin
      hl  <= HW'(a0l) <<< 16;
      hr  <= HW'(a0r) <<< 16;
      a1l <= 20'(yl[0]) - 20'(yl[1]) - a0l;
      a1r <= 20'(yr[0]) - 20'(yr[1]) - a0r;
      a2l <= 20'(yl[2]) - 20'(yl[0]);
      a2r <= 20'(yr[2]) - 20'(yr[0]);
      a3l <= 20'(yl[1]);
      a3r <= 20'(yr[1]);
    end else if (cmd.horner != 2'd0) begin
      hl <= HW'(pl >>> 16) + (HW'(addl) <<< 16);
      hr <= HW'(pr >>> 16) + (HW'(addr_r) <<< 16);
    end
  end

  // Dither, saturation and truncation toward zero.
  logic [15:0] lfsr1, lfsr2;
  function automatic logic [15:0] lfsr_step(input logic [15:0] x);
    return {x[0] ^ x[2] ^ x[3] ^ x[5], x[15:1]};
  endfunction
  function automatic logic [15:0] sat(input logic signed [HW-1:0] v);
    logic [HW-1:0] mag;
    if (v >= $signed(HW'(32767) <<< 16)) return 16'h7fff;
    if (v < -($signed(HW'(32768) <<< 16))) return 16'h8000;
    if (!v[HW-1]) return 16'(v >>> 16);
    mag = HW'(-v) >> 16;
    return 16'(-mag);
  endfunction

  assign lfsr1 = lfsr_step(lfsr);
  assign lfsr2 = lfsr_step(lfsr1);

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= crd_pkg::LfsrReset;
    end else if (cmd.finish) begin
      lfsr <= lfsr2;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      left_out  <= sat(hl + HW'($signed({1'b0, lfsr1}) - 17'sd32768));
      right_out <= sat(hr + HW'($signed({1'b0, lfsr2}) - 17'sd32768));
    end
  end

endmodule

>>> rtl/cubic_resampler_with_dither.sv
// ----------------------------------------------------------------------------
// cubic_resampler_with_dither: stereo cubic resampler
// Frame memory, playback position and dithered cubic interpolation.
// ----------------------------------------------------------------------------
// Write and set-position beats do not stall the input side. A tick beat
// stalls it after its accepting cycle, through four window frame reads one
// after another through the single port of the frame memory, a capture step
// for the last frame, one coefficient step, three Horner steps through the
// multiplier of each channel and a final dither and saturate step. The result
// is held in an output register; a new beat can be taken while it waits, and
// the final step of the next tick waits until that result has been delivered.
module cubic_resampler_with_dither #(
  parameter int TrackFrames  = crd_pkg::TrackFramesDefault,
  parameter int FractionBits = crd_pkg::FractionBitsDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [crd_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [crd_pkg::CfgW-1:0]         cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       action,
  input  logic [crd_pkg::AddrInW-1:0]      frame_address,
  input  logic signed [crd_pkg::SampW-1:0] left_sample,
  input  logic signed [crd_pkg::SampW-1:0] right_sample,
  input  logic signed [crd_pkg::PosW-1:0]  start_position,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [crd_pkg::SampW-1:0] left_out,
  output logic signed [crd_pkg::SampW-1:0] right_out
);

  crd_pkg::crd_cmd_t cmd;

  crd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .action    (action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  crd_datapath #(.TrackFrames(TrackFrames), .FractionBits(FractionBits)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_index),
    .cfg_data       (cfg_data),
    .frame_address  (frame_address),
    .left_sample    (left_sample),
    .right_sample   (right_sample),
    .start_position (start_position),
    .left_out       (left_out),
    .right_out      (right_out)
  );

endmodule

>>> rtl/crd_checker.sv
// ----------------------------------------------------------------------------
// crd_checker: port-level checks of the resampler
// Watches the handshakes and the timing of results.
// ----------------------------------------------------------------------------
module crd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  action,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] left_out
);

  // A held result keeps its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(left_out))
    else $error("stalled result changed");

  // A write beat gives no result next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action == 2'd0 && !out_valid |=> !out_valid)
    else $error("result from a write beat");

  // A set-position beat gives no result next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action == 2'd1 && !out_valid |=> !out_valid)
    else $error("result from a set-position beat");

  // A tick keeps the input side stalled in the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action == 2'd2 |=> in_stall)
    else $error("tick not sequenced");

endmodule

bind cubic_resampler_with_dither crd_checker u_crd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .action    (action),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .left_out  (left_out)
);
